@@ rtl/els_pkg.sv @@
// ============================================================================
// els_pkg - shared types and constants of the expression list splitter
// Character codes, the scanner states and the result record that the
// scanner front end hands to the output back end.
// ============================================================================
package els_pkg;

    // Offsets are 13 bits wide and saturate at MAX_LEN.
    localparam int unsigned POS_W   = 13;
    localparam int unsigned MAX_LEN = 4096;

    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_LBRACK    = 8'h5B;
    localparam logic [7:0] CH_RBRACK    = 8'h5D;
    localparam logic [7:0] CH_LESS      = 8'h3C;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LF        = 8'h0A;

    typedef enum logic [2:0] {
        ST_START,
        ST_LEAD_WS,
        ST_NORMAL,
        ST_IN_STRING,
        ST_IN_CHAR,
        ST_AFTER_STRING,
        ST_REJECT
    } scan_state_t;

    typedef struct packed {
        logic [POS_W-1:0] seg_start;
        logic [POS_W-1:0] seg_end;
        logic             is_message;
        logic             last_segment;
        logic             too_long;
    } els_res_t;

    // A record holds the one or two results of one accepted byte; two_res marks the second.
    typedef struct packed {
        logic     two_res;
        els_res_t res0;
        els_res_t res1;
    } els_rec_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    // Builds a result; the end never lies below the start.
    function automatic els_res_t make_res(input logic [POS_W-1:0] b,
                                          input logic [POS_W-1:0] e,
                                          input logic lit,
                                          input logic last,
                                          input logic ovf);
        els_res_t r;
        r.seg_start    = b;
        r.seg_end      = (e < b) ? b : e;
        r.is_message   = lit;
        r.last_segment = last;
        r.too_long     = ovf;
        return r;
    endfunction

endpackage

@@ rtl/expression_list_splitter.sv @@
// ============================================================================
// expression_list_splitter - splits expression text into list segments
// Scans text one character per beat and reports the segments between
// top-level separators.
// ============================================================================
//
// Usage. The input stream carries one character of expression text per
// beat in s_tdata, with s_tlast on the final character of a text. The
// result stream gives one segment per beat: its start and end offsets in
// m_tdata, the literal-only and too-long flags in m_tuser, and m_tlast on
// the final segment of the text. The split mode register (cfg_wr_en,
// cfg_wr_data) picks "<<" splitting (0) or parenthesized comma lists (1);
// write it only while no text is in flight.
//
// Throughput is one character per cycle while the record queue has room. A
// character that produces two results (a separator on the final character)
// needs two output beats, so a stream of those drains at one result per
// cycle through the queue while the receiver is ready.
// The scanner is combinational: the record of a character enters the queue
// at its accepting edge, and the output register loads it from the queue
// once the output is free; m_tvalid is driven from that register.
//
// Reset clears the scanner, the queue and the output stage and sets split
// mode 0. When the receiver stalls, results collect in the record queue;
// s_tready drops only once the queue is full, so the scanner keeps taking
// characters while a result waits on the output.
//
module expression_list_splitter import els_pkg::*; #(
    parameter int unsigned MAX_DEPTH  = 127,  // nesting level saturation
    parameter int unsigned FIFO_DEPTH = 4     // records between front and back
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,   // split_mode

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] text_byte
    input  logic        s_tlast,       // last_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,       // [12:0] seg_start, [25:13] seg_end, rest zero
    output logic [1:0]  m_tuser,       // [0] is_message, [1] too_long
    output logic        m_tlast        // last_segment
);

    logic     in_fire;
    logic     rec_push;
    els_rec_t rec_data;
    els_rec_t head_data;
    logic     q_empty;
    logic     q_full;
    logic     q_pop;
    els_res_t out_res;

    // The queue always has room for a record when a beat is taken.
    assign s_tready = !q_full;
    assign in_fire  = s_tvalid && s_tready;

    els_front #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_fire     (in_fire),
        .in_byte     (s_tdata),
        .in_last     (s_tlast),
        .rec_push    (rec_push),
        .rec_data    (rec_data)
    );

    els_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (rec_push),
        .push_data (rec_data),
        .pop       (q_pop),
        .head_data (head_data),
        .empty     (q_empty),
        .full      (q_full)
    );

    els_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_data (head_data),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_res   (out_res)
    );

    // Pack the result fields onto the output beat.
    assign m_tdata = {6'b0, out_res.seg_end, out_res.seg_start};
    assign m_tuser = {out_res.too_long, out_res.is_message};
    assign m_tlast = out_res.last_segment;

endmodule

@@ rtl/els_front.sv @@
// ============================================================================
// els_front - byte scanner
// Tracks nesting, literals and whitespace for each accepted byte and forms
// the result record of the separators and text ends that it finds.
// ============================================================================
module els_front import els_pkg::*; #(
    parameter int unsigned MAX_DEPTH = 127
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       in_fire,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       rec_push,
    output els_rec_t   rec_data
);

    localparam int unsigned NW = $clog2(MAX_DEPTH + 1) + 1;
    localparam logic signed [NW-1:0] NEST_HI = NW'(MAX_DEPTH);
    localparam logic signed [NW-1:0] NEST_LO = -NEST_HI;

    logic                 split_mode_reg;
    logic [POS_W-1:0]     position_reg, position_next;
    logic [POS_W-1:0]     seg_begin_reg, seg_begin_next;
    logic [POS_W-1:0]     trim_end_reg, trim_end_next;
    logic signed [NW-1:0] nest_reg, nest_next;
    scan_state_t          state_reg, state_next;
    logic                 lit_only_reg, lit_only_next;
    logic                 pend_less_reg, pend_less_next;
    logic                 ovf_reg, ovf_next;
    logic                 esc_reg, esc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            split_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            split_mode_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_START;
        end else if (in_fire) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg  <= '0;
            seg_begin_reg <= '0;
            trim_end_reg  <= '0;
            nest_reg      <= '0;
            lit_only_reg  <= 1'b1;
            pend_less_reg <= 1'b0;
            ovf_reg       <= 1'b0;
            esc_reg       <= 1'b0;
        end else if (in_fire) begin
            position_reg  <= position_next;
            seg_begin_reg <= seg_begin_next;
            trim_end_reg  <= trim_end_next;
            nest_reg      <= nest_next;
            lit_only_reg  <= lit_only_next;
            pend_less_reg <= pend_less_next;
            ovf_reg       <= ovf_next;
            esc_reg       <= esc_next;
        end
    end

    always_comb begin
        logic [POS_W-1:0] cur;
        logic [POS_W-1:0] nxt;
        logic [POS_W-1:0] fin_end;
        logic             ws;
        logic             handle;
        logic             done;
        logic             split;
        logic             emit;
        logic [7:0]       quote;
        scan_state_t      after_q;
        els_res_t         split_res;
        els_res_t         fin_res;

        position_next  = position_reg;
        seg_begin_next = seg_begin_reg;
        trim_end_next  = trim_end_reg;
        nest_next      = nest_reg;
        state_next     = state_reg;
        lit_only_next  = lit_only_reg;
        pend_less_next = pend_less_reg;
        ovf_next       = ovf_reg;
        esc_next       = esc_reg;
        ws             = is_ws(in_byte);
        handle         = 1'b0;
        done           = 1'b0;
        split          = 1'b0;
        quote          = CH_DQUOTE;
        after_q        = ST_AFTER_STRING;
        split_res      = '0;
        fin_end        = '0;

        cur = position_reg;
        if (position_reg < POS_W'(MAX_LEN)) begin
            position_next = position_reg + POS_W'(1);
        end else begin
            ovf_next = 1'b1;
        end
        nxt = position_next;

        if (state_reg == ST_IN_CHAR) begin
            quote   = CH_SQUOTE;
            after_q = ST_NORMAL;
        end

        case (state_reg)
            ST_START: begin
                if (ws) begin
                    seg_begin_next = nxt;
                    trim_end_next  = nxt;
                end else if (split_mode_reg) begin
                    if (in_byte == CH_LPAREN) begin
                        state_next     = ST_LEAD_WS;
                        seg_begin_next = nxt;
                        trim_end_next  = nxt;
                    end else begin
                        state_next = ST_REJECT;
                    end
                end else begin
                    seg_begin_next = cur;
                    trim_end_next  = cur;
                    state_next     = ST_NORMAL;
                    handle         = 1'b1;
                end
            end
            ST_LEAD_WS: begin
                if (ws) begin
                    seg_begin_next = nxt;
                    trim_end_next  = nxt;
                end else begin
                    seg_begin_next = cur;
                    trim_end_next  = cur;
                    state_next     = ST_NORMAL;
                    handle         = 1'b1;
                end
            end
            ST_AFTER_STRING: begin
                if (!ws) begin
                    state_next = ST_NORMAL;
                    handle     = 1'b1;
                end
            end
            ST_IN_STRING, ST_IN_CHAR: begin
                if (!ws) begin
                    trim_end_next = nxt;
                end
                if (esc_reg) begin
                    esc_next = 1'b0;
                end else if (in_byte == CH_BACKSLASH) begin
                    esc_next = 1'b1;
                end else if (in_byte == quote) begin
                    state_next = after_q;
                end
            end
            ST_NORMAL: begin
                handle = 1'b1;
            end
            default: begin
            end
        endcase

        if (handle) begin
            // A held top-level '<' either completes a shift operator or
            // turns out to be an ordinary character.
            if (pend_less_reg) begin
                pend_less_next = 1'b0;
                if (in_byte == CH_LESS) begin
                    split = 1'b1;
                    done  = 1'b1;
                end else begin
                    trim_end_next = cur;
                end
            end
            if (!done) begin
                case (in_byte)
                    CH_LPAREN, CH_LBRACK: begin
                        if (nest_next < NEST_HI) begin
                            nest_next = nest_next + NW'(1);
                        end
                        lit_only_next = 1'b0;
                    end
                    CH_RPAREN, CH_RBRACK: begin
                        if (nest_next > NEST_LO) begin
                            nest_next = nest_next - NW'(1);
                        end
                        if (!split_mode_reg) begin
                            lit_only_next = 1'b0;
                        end
                    end
                    CH_LESS: begin
                        if (!split_mode_reg) begin
                            if (nest_next == '0) begin
                                pend_less_next = 1'b1;
                                done           = 1'b1;
                            end
                        end else begin
                            lit_only_next = 1'b0;
                        end
                    end
                    CH_COMMA: begin
                        if (split_mode_reg) begin
                            if (nest_next == '0) begin
                                split = 1'b1;
                                done  = 1'b1;
                            end
                        end else begin
                            lit_only_next = 1'b0;
                        end
                    end
                    CH_DQUOTE: begin
                        state_next = ST_IN_STRING;
                    end
                    CH_SQUOTE: begin
                        state_next    = ST_IN_CHAR;
                        lit_only_next = 1'b0;
                    end
                    default: begin
                        lit_only_next = 1'b0;
                    end
                endcase
                if (!done && !ws) begin
                    trim_end_next = nxt;
                end
            end
        end

        if (split) begin
            split_res = make_res(seg_begin_next, trim_end_next, lit_only_next,
                                 1'b0, ovf_next);
            seg_begin_next = nxt;
            trim_end_next  = nxt;
            lit_only_next  = 1'b1;
            state_next     = ST_LEAD_WS;
        end

        emit = !((state_next == ST_REJECT) || ((state_next == ST_START) && split_mode_reg));
        if (split_mode_reg) begin
            fin_end = position_next - POS_W'(1);
        end else begin
            fin_end = position_next;
        end
        fin_res = make_res(seg_begin_next, fin_end, lit_only_next, 1'b1, ovf_next);

        rec_push = in_fire && (split || (in_last && emit));
        if (split) begin
            rec_data.res0    = split_res;
            rec_data.res1    = fin_res;
            rec_data.two_res = in_last && emit;
        end else begin
            rec_data.res0    = fin_res;
            rec_data.res1    = fin_res;
            rec_data.two_res = 1'b0;
        end

        // The last byte of a text returns the scanner to its idle state.
        if (in_last) begin
            position_next  = '0;
            seg_begin_next = '0;
            trim_end_next  = '0;
            nest_next      = '0;
            state_next     = ST_START;
            lit_only_next  = 1'b1;
            pend_less_next = 1'b0;
            ovf_next       = 1'b0;
            esc_next       = 1'b0;
        end
    end

    a_ovf_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (position_reg == POS_W'(MAX_LEN)))
        else $error("overflow flag set below the saturated position");

    a_start_tracks_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_START) |-> (seg_begin_reg == position_reg))
        else $error("segment begin lost track of position before first token");

endmodule

@@ rtl/els_fifo.sv @@
// ============================================================================
// els_fifo - record queue
// Small first-word-fall-through queue of result records between the
// scanner and the output stage.
// ============================================================================
module els_fifo import els_pkg::*; #(
    parameter int unsigned DEPTH = 4   // two or more
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  els_rec_t push_data,
    input  logic     pop,
    output els_rec_t head_data,
    output logic     empty,
    output logic     full
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    els_rec_t         store [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store[wr_ptr_reg] <= push_data;
        end
    end

    assign head_data = store[rd_ptr_reg];
    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CNT_W'(DEPTH));

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

@@ rtl/els_back.sv @@
// ============================================================================
// els_back - result output stage
// Takes records from the queue and presents their results one beat at a
// time from an output register, holding a second result aside.
// ============================================================================
module els_back import els_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  els_rec_t head_data,
    input  logic     q_empty,
    output logic     q_pop,
    input  logic     out_ready,
    output logic     out_valid,
    output els_res_t out_res
);

    logic     out_valid_reg, out_valid_next;
    els_res_t out_res_reg, out_res_next;
    logic     pend_valid_reg, pend_valid_next;
    els_res_t pend_res_reg, pend_res_next;
    logic     out_free;

    always_comb begin
        out_free        = !out_valid_reg || out_ready;
        out_valid_next  = out_valid_reg && !out_ready;
        out_res_next    = out_res_reg;
        pend_valid_next = pend_valid_reg;
        pend_res_next   = pend_res_reg;
        q_pop           = 1'b0;
        if (out_free) begin
            if (pend_valid_reg) begin
                out_valid_next  = 1'b1;
                out_res_next    = pend_res_reg;
                pend_valid_next = 1'b0;
            end else if (!q_empty) begin
                q_pop           = 1'b1;
                out_valid_next  = 1'b1;
                out_res_next    = head_data.res0;
                pend_valid_next = head_data.two_res;
                pend_res_next   = head_data.res1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg  <= out_res_next;
        pend_res_reg <= pend_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    a_pend_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> out_valid_reg)
        else $error("second result held without a first one on the output");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb - self-checking testbench of the expression list splitter
// Streams expression text into the splitter one character per beat, predicts
// every segment with a behavioral scanner kept inside the bench, and compares
// each segment beat field by field. Directed texts come first, then random
// well-formed lists with random content, noise and broken lists mixed in.
// ============================================================================
module tb;
    import els_pkg::*;

    localparam int DEPTH_LIMIT   = 127;  // nesting level saturation of the block
    localparam int SETTLE_CYCLES = 6;    // covers the queue and output register, with margin
    localparam int RANDOM_CHARS  = 1130; // characters in the random phase
    localparam int CALM_CHARS    = 200;  // final stretch without any idling

    // One expected segment, in the order the splitter must deliver them.
    typedef struct {
        logic [POS_W-1:0] seg_start;
        logic [POS_W-1:0] seg_end;
        bit               is_message;
        bit               last_segment;
        bit               too_long;
    } segment_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // Segments still owed by the splitter, oldest first.
    segment_t segments_due[$];
    int       mismatches = 0;
    int       chars_sent = 0;

    // Text under construction before it is streamed.
    logic [7:0] text_buf[$];

    // Idling controls: calm switches all idling off for the final stretch.
    bit calm          = 1'b0;
    bit sender_jitter = 1'b1;
    bit sink_jitter   = 1'b1;
    int hold_left     = 0;

    // Scanner state of the prediction, mirrors what the splitter keeps.
    bit               split_mode_q;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] seg_begin;
    logic [POS_W-1:0] trim_end;
    int               nest;
    scan_state_t      scan;
    bit               lit_only;
    bit               less_pending;
    bit               ovf;
    bit               escaped;

    always #5 aclk = ~aclk;

    expression_list_splitter dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // ------------------------------------------------------------------------
    // Segment prediction
    // ------------------------------------------------------------------------

    function automatic bit blank(input logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
    endfunction

    // Every text starts from this state; only the split mode survives it.
    function automatic void clear_scan();
        pos          = '0;
        seg_begin    = '0;
        trim_end     = '0;
        nest         = 0;
        scan         = ST_START;
        lit_only     = 1'b1;
        less_pending = 1'b0;
        ovf          = 1'b0;
        escaped      = 1'b0;
    endfunction

    // The end of a segment is raised to its start when trimming left it lower.
    function automatic void owe_segment(input logic [POS_W-1:0] b, input logic [POS_W-1:0] e,
                                        input bit lit, input bit fin);
        segment_t s;
        s.seg_start    = b;
        s.seg_end      = (e < b) ? b : e;
        s.is_message   = lit;
        s.last_segment = fin;
        s.too_long     = ovf;
        segments_due.push_back(s);
    endfunction

    // A top-level separator closes the open segment; the next one starts
    // after the separator and skips its leading whitespace.
    function automatic void cut_segment(input logic [POS_W-1:0] nxt);
        owe_segment(seg_begin, trim_end, lit_only, 1'b0);
        seg_begin = nxt;
        trim_end  = nxt;
        lit_only  = 1'b1;
        scan      = ST_LEAD_WS;
    endfunction

    // Inside a string or char literal: track escapes and the closing quote.
    function automatic void scan_quoted(input logic [7:0] c, input logic [POS_W-1:0] nxt,
                                        input logic [7:0] quote, input scan_state_t after);
        if (!blank(c)) trim_end = nxt;
        if (escaped) begin
            escaped = 1'b0;
        end else if (c == CH_BACKSLASH) begin
            escaped = 1'b1;
        end else if (c == quote) begin
            scan = after;
        end
    endfunction

    // A character outside literals: brackets, separators and the literal flag.
    function automatic void scan_code(input logic [7:0] c, input logic [POS_W-1:0] cur,
                                      input logic [POS_W-1:0] nxt);
        if (less_pending) begin
            less_pending = 1'b0;
            if (c == CH_LESS) begin
                cut_segment(nxt);
                return;
            end
            // The lone '<' turned out to be part of the segment after all.
            trim_end = cur;
        end
        case (c)
            CH_LPAREN, CH_LBRACK: begin
                if (nest < DEPTH_LIMIT) nest++;
                lit_only = 1'b0;
            end
            CH_RPAREN, CH_RBRACK: begin
                if (nest > -DEPTH_LIMIT) nest--;
                if (!split_mode_q) lit_only = 1'b0;
            end
            CH_LESS: begin
                if (!split_mode_q) begin
                    if (nest == 0) begin
                        less_pending = 1'b1;
                        return;
                    end
                end else begin
                    lit_only = 1'b0;
                end
            end
            CH_COMMA: begin
                if (split_mode_q) begin
                    if (nest == 0) begin
                        cut_segment(nxt);
                        return;
                    end
                end else begin
                    lit_only = 1'b0;
                end
            end
            CH_DQUOTE: scan = ST_IN_STRING;
            CH_SQUOTE: begin
                scan     = ST_IN_CHAR;
                lit_only = 1'b0;
            end
            default: lit_only = 1'b0;
        endcase
        if (!blank(c)) trim_end = nxt;
    endfunction

    // Works out the segments that one accepted character releases.
    function automatic void predict_segments(input logic [7:0] c, input bit fin);
        logic [POS_W-1:0] cur;
        logic [POS_W-1:0] nxt;
        logic [POS_W-1:0] stop;
        bit               code;
        cur  = pos;
        code = 1'b0;
        // Offsets stop counting at the length limit and flag the text instead.
        if (pos < MAX_LEN) pos++;
        else ovf = 1'b1;
        nxt = pos;
        case (scan)
            ST_START: begin
                if (blank(c)) begin
                    seg_begin = nxt;
                    trim_end  = nxt;
                end else if (split_mode_q) begin
                    if (c == CH_LPAREN) begin
                        scan      = ST_LEAD_WS;
                        seg_begin = nxt;
                        trim_end  = nxt;
                    end else begin
                        scan = ST_REJECT;
                    end
                end else begin
                    seg_begin = cur;
                    trim_end  = cur;
                    scan      = ST_NORMAL;
                    code      = 1'b1;
                end
            end
            ST_LEAD_WS: begin
                if (blank(c)) begin
                    seg_begin = nxt;
                    trim_end  = nxt;
                end else begin
                    seg_begin = cur;
                    trim_end  = cur;
                    scan      = ST_NORMAL;
                    code      = 1'b1;
                end
            end
            ST_AFTER_STRING: begin
                if (!blank(c)) begin
                    scan = ST_NORMAL;
                    code = 1'b1;
                end
            end
            ST_IN_STRING: scan_quoted(c, nxt, CH_DQUOTE, ST_AFTER_STRING);
            ST_IN_CHAR:   scan_quoted(c, nxt, CH_SQUOTE, ST_NORMAL);
            ST_NORMAL:    code = 1'b1;
            default:      ;
        endcase
        if (code) scan_code(c, cur, nxt);
        if (fin) begin
            // A comma list that never opened gives nothing at all.
            if (!(scan == ST_REJECT || (scan == ST_START && split_mode_q))) begin
                // In comma mode the closing character is not part of the list.
                if (!split_mode_q) stop = pos;
                else stop = (pos > 0) ? pos - 1'b1 : '0;
                owe_segment(seg_begin, stop, lit_only, 1'b1);
            end
            clear_scan();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic compare_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    // Every accepted result beat is held against the oldest owed segment.
    always @(posedge aclk) begin
        segment_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (segments_due.size() == 0) begin
                $display("%0t ns: no segment expected, got start %0d end %0d flags %b last %b",
                         $time, m_tdata[12:0], m_tdata[25:13], m_tuser, m_tlast);
                mismatches++;
            end else begin
                want = segments_due.pop_front();
                compare_field("seg_start", int'(want.seg_start), int'(m_tdata[12:0]));
                compare_field("seg_end", int'(want.seg_end), int'(m_tdata[25:13]));
                compare_field("m_tdata padding", 0, int'(m_tdata[31:26]));
                compare_field("is_message", int'(want.is_message), int'(m_tuser[0]));
                compare_field("too_long", int'(want.too_long), int'(m_tuser[1]));
                compare_field("last_segment", int'(want.last_segment), int'(m_tlast));
            end
        end
    end

    // Receiver side: random stall bursts, in stretches that come and go, and
    // none at all once the run turns calm.
    always @(posedge aclk) begin
        if ($urandom_range(0, 63) == 0) sink_jitter = !sink_jitter;
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (!calm && sink_jitter && $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(0, 6);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Offers one character and returns at the edge that accepts it. The
    // valid stays high on return so a following beat can go out back to back.
    task automatic send_char(input logic [7:0] c, input bit fin);
        if (!calm && sender_jitter && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        predict_segments(c, fin);
        chars_sent++;
    endtask

    // Streams the built text; closes marks its final character as the last.
    task automatic send_buffer(input bit closes);
        foreach (text_buf[i]) send_char(text_buf[i], closes && (i == text_buf.size() - 1));
    endtask

    function automatic void add_str(input string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endfunction

    function automatic void add_run(input logic [7:0] c, input int n);
        repeat (n) text_buf.push_back(c);
    endfunction

    task automatic send_text(input string s, input bit closes = 1'b1);
        text_buf.delete();
        add_str(s);
        send_buffer(closes);
    endtask

    // Lets the splitter run dry: every owed segment in, then SETTLE_CYCLES of
    // settling for characters that release nothing but may still be in the pipeline.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (segments_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Only call with the splitter drained.
    task automatic write_mode(input bit m);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        split_mode_q = m;
    endtask

    // ------------------------------------------------------------------------
    // Random text generation
    // ------------------------------------------------------------------------

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] pick_letter();
        return 8'h61 + 8'($urandom_range(0, 25));
    endfunction

    // Appends one list item: a few tokens, possibly with nested brackets
    // that hide separators, and literals that hide separators and brackets.
    function automatic void add_item(input int lvl);
        int n;
        n = $urandom_range(1, 3);
        repeat (n) begin
            case ($urandom_range(0, 11))
                0, 1: repeat ($urandom_range(1, 4)) text_buf.push_back(pick_letter());
                2, 3: begin
                    text_buf.push_back(CH_DQUOTE);
                    repeat ($urandom_range(0, 5)) begin
                        case ($urandom_range(0, 6))
                            0: begin
                                text_buf.push_back(CH_BACKSLASH);
                                text_buf.push_back($urandom_range(0, 1) ? CH_DQUOTE : pick_letter());
                            end
                            1: text_buf.push_back(CH_COMMA);
                            2: text_buf.push_back(CH_LESS);
                            3: text_buf.push_back($urandom_range(0, 1) ? CH_LPAREN : CH_RBRACK);
                            4: text_buf.push_back(pick_blank());
                            default: text_buf.push_back(pick_letter());
                        endcase
                    end
                    // Now and then the literal is left open.
                    if ($urandom_range(0, 9) != 0) text_buf.push_back(CH_DQUOTE);
                end
                4: begin
                    text_buf.push_back(CH_SQUOTE);
                    if ($urandom_range(0, 2) == 0) text_buf.push_back(CH_BACKSLASH);
                    text_buf.push_back($urandom_range(0, 1) ? CH_SQUOTE : pick_letter());
                    text_buf.push_back(CH_SQUOTE);
                end
                5, 6: begin
                    if (lvl < 2) begin
                        text_buf.push_back($urandom_range(0, 1) ? CH_LPAREN : CH_LBRACK);
                        add_item(lvl + 1);
                        repeat ($urandom_range(0, 2)) begin
                            if ($urandom_range(0, 1)) text_buf.push_back(CH_COMMA);
                            else add_run(CH_LESS, 2);
                            add_item(lvl + 1);
                        end
                        text_buf.push_back($urandom_range(0, 1) ? CH_RPAREN : CH_RBRACK);
                    end else begin
                        text_buf.push_back(pick_letter());
                    end
                end
                7:  text_buf.push_back(CH_LESS);
                8:  repeat ($urandom_range(1, 3)) text_buf.push_back(pick_blank());
                9:  text_buf.push_back(8'($urandom_range(1, 255)));
                10: text_buf.push_back($urandom_range(0, 1) ? CH_RPAREN : CH_LBRACK);
                default: repeat ($urandom_range(1, 3))
                    text_buf.push_back(8'h30 + 8'($urandom_range(0, 9)));
            endcase
        end
    endfunction

    // Mostly well-formed lists for the current mode; the rest is noise or a
    // list with its opening or closing part broken.
    function automatic void build_random_text();
        int k;
        text_buf.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 16)) text_buf.push_back(8'($urandom_range(1, 255)));
            return;
        end
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) text_buf.push_back(pick_blank());
        if (split_mode_q) begin
            if ($urandom_range(0, 11) != 0) text_buf.push_back(CH_LPAREN);
            else text_buf.push_back(pick_letter());
        end
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++) begin
            if ($urandom_range(0, 2) == 0) text_buf.push_back(pick_blank());
            if ($urandom_range(0, 11) != 0) add_item(0);
            if ($urandom_range(0, 2) == 0) text_buf.push_back(pick_blank());
            if (i < k - 1) begin
                if (split_mode_q) text_buf.push_back(CH_COMMA);
                else add_run(CH_LESS, 2);
            end
        end
        // A separator right before the end gives an empty final segment.
        if ($urandom_range(0, 7) == 0) begin
            if (split_mode_q) text_buf.push_back(CH_COMMA);
            else add_run(CH_LESS, 2);
        end
        if (split_mode_q && $urandom_range(0, 9) != 0) text_buf.push_back(CH_RPAREN);
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Shift-operator splitting: literals, nesting, empty segments, lone '<',
    // whitespace-only text, open literals and the extreme character codes.
    task automatic test_shift_split();
        write_mode(1'b0);
        send_text("a << b");
        send_text(" \"x\" \"y\"  << f(a<<b)[1<<2] <<");
        send_text("<<  \t<<");
        send_text(" \t\015\n");
        send_text("a<b << 'c' << \"s\\\"<<\"");
        send_text("\"open \\");
        send_char(8'h01, 1'b0);
        send_char(8'hFF, 1'b1);
        send_char(8'h80, 1'b1);
        send_char(8'h7F, 1'b1);
        drain_results();
    endtask

    // Comma lists: nested commas, literals, empty items, rejected texts.
    task automatic test_comma_split();
        write_mode(1'b1);
        send_text("(a, b)");
        send_text("  ( \"m\" , x[1,2] , \"p\" \"q\"  )");
        send_text("(a,,)");
        send_text("x(a,b)");
        send_text(" \t ");
        send_text("(");
        send_text("()");
        send_text("(a), b), (c ',' < d)");
        drain_results();
    endtask

    // The split mode changes halfway through a text while it is drained.
    task automatic test_mode_switch();
        write_mode(1'b0);
        send_text(" x << y, z", 1'b0);
        drain_results();
        write_mode(1'b1);
        send_text(", w << v)");
        send_text("(a, b", 1'b0);
        drain_results();
        write_mode(1'b0);
        send_text(" << c, d)");
        drain_results();
    endtask

    // Nesting saturates at both ends; afterwards the level returns to zero
    // after exactly the saturated count, so the separators that follow split.
    task automatic test_nesting_limits();
        write_mode(1'b0);
        text_buf.delete();
        add_run(CH_LPAREN, DEPTH_LIMIT + 3);
        add_run(CH_RPAREN, DEPTH_LIMIT);
        add_str("<<");
        add_run(CH_RPAREN, DEPTH_LIMIT + 5);
        add_run(CH_LPAREN, DEPTH_LIMIT);
        add_str("<< e");
        send_buffer(1'b1);
        // Unbalanced: a negative level keeps later separators from splitting.
        send_text("a)) << b");
        drain_results();
    endtask

    task automatic test_random_texts();
        int first;
        first = chars_sent;
        while (chars_sent - first < RANDOM_CHARS) begin
            if (chars_sent - first > RANDOM_CHARS - CALM_CHARS) calm = 1'b1;
            // Mode changes need a drained splitter, which also lets the
            // sender hold off until everything owed has come back.
            if (!calm && $urandom_range(0, 4) == 0) begin
                drain_results();
                write_mode(1'($urandom_range(0, 1)));
            end
            sender_jitter = ($urandom_range(0, 2) != 0);
            build_random_text();
            send_buffer(1'b1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------------

    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tlast     <= 1'b0;
        split_mode_q = 1'b0;
        clear_scan();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_shift_split();
        test_comma_split();
        test_mode_switch();
        test_nesting_limits();
        test_random_texts();
        drain_results();

        if (segments_due.size() != 0) begin
            $display("%0t ns: %0d segments never arrived", $time, segments_due.size());
        end
        if (mismatches == 0 && segments_due.size() == 0) begin
            $display("expression_list_splitter regression: pass");
        end else begin
            $display("expression_list_splitter regression: fail");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #8ms;
        $display("expression_list_splitter regression: fail");
        $finish;
    end

endmodule
